@@ hw/rtl/crc16p_pkg.sv @@
package crc16p_pkg;

  // CRC width and generator polynomial (x^16 + x^15 + x^2 + 1)
  localparam int unsigned CRC_W = 16;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;

  typedef logic [CRC_W-1:0] crc_t;

  // One serial LFSR step: shift in a single data bit, MSB first
  function automatic crc_t crc_step(crc_t c, logic b);
    logic fb;
    fb = c[CRC_W-1] ^ b;
    return {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  endfunction

endpackage

@@ hw/rtl/crc16p_fold.sv @@
module crc16p_fold import crc16p_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  crc_t                  crc_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  output crc_t                  crc_o
);

  // Contribution of one start CRC value and one data bit position after a full word
  function automatic crc_t fold_unit(crc_t c, int dbit);
    crc_t r;
    r = c;
    for (int j = DATA_WIDTH - 1; j >= 0; j--) begin
      r = crc_step(r, (j == dbit));
    end
    return r;
  endfunction

  // Column of the XOR matrix for every data bit
  function automatic logic [DATA_WIDTH-1:0][CRC_W-1:0] build_data_mat();
    logic [DATA_WIDTH-1:0][CRC_W-1:0] m;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      m[i] = fold_unit('0, i);
    end
    return m;
  endfunction

  // Column of the XOR matrix for every bit of the old CRC
  function automatic logic [CRC_W-1:0][CRC_W-1:0] build_crc_mat();
    logic [CRC_W-1:0][CRC_W-1:0] m;
    for (int k = 0; k < CRC_W; k++) begin
      m[k] = fold_unit(crc_t'(1) << k, -1);
    end
    return m;
  endfunction

  localparam logic [DATA_WIDTH-1:0][CRC_W-1:0] DATA_MAT = build_data_mat();
  localparam logic [CRC_W-1:0][CRC_W-1:0]      CRC_MAT  = build_crc_mat();

  // XOR together the columns selected by set bits
  always_comb begin
    crc_o = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (data_i[i]) crc_o = crc_o ^ DATA_MAT[i];
    end
    for (int k = 0; k < CRC_W; k++) begin
      if (crc_i[k]) crc_o = crc_o ^ CRC_MAT[k];
    end
  end

endmodule

@@ hw/rtl/crc16_parallel_64bit.sv @@
// Channel     Dir  Payload                                   Transfer
// s_axis      in   tdata: data_word[63:0], tuser: block_start  tvalid & tready
// m_axis      out  tdata: crc_out[15:0]                      tvalid & tready
// cfg         in   cfg_wdata_i: crc_seed[15:0]              cfg_we_i
//
// One word per clock sustained while the output is not stalled; the result is registered.
// The word sits in an input register, the XOR matrix folds it into the running CRC,
// and the result register holds the updated CRC until the output transfer.
// Reset clears the running CRC, the seed and both valid flags.
// A stalled output holds the result; the input stage takes a word whenever it is
// empty or its word moves on in the same cycle.
module crc16_parallel_64bit import crc16p_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // crc_seed
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // [63:0] data_word
  input  logic        s_axis_tuser,    // [0] block_start
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // [15:0] crc_out
);

  crc_t                  seed_q;
  crc_t                  crc_q, crc_d;
  logic                  in_valid_q;
  logic [DATA_WIDTH-1:0] in_data_q;
  logic                  in_start_q;
  logic                  out_valid_q;
  crc_t                  out_crc_q;
  logic                  out_load;
  logic                  in_load;

  // Hold the seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // Advance the two stages
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Capture the input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q  <= s_axis_tdata[DATA_WIDTH-1:0];
      in_start_q <= s_axis_tuser;
    end
  end

  // Fold the word into the running CRC, or into the seed at block start
  crc16p_fold #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_fold (
    .crc_i  (in_start_q ? seed_q : crc_q),
    .data_i (in_data_q),
    .crc_o  (crc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_crc_q <= crc_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;

  // The shown result is always the running CRC
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_crc_q == crc_q))
    else $error("result register differs from running CRC");

  // Input stage refuses only while it holds a word
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input stage stalled while empty");

  // A result leaves only through an output transfer
  a_result_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(m_axis_tready))
    else $error("result dropped without transfer");

endmodule

@@ dv/tb_crc16_parallel_64bit.sv @@
module tb_crc16_parallel_64bit;
  import crc16p_pkg::*;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned RAND_WORDS  = 435;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned IDLE_PCT    = 24;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              block_start;
  } word_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;    // [63:0] data_word
  logic        s_axis_tuser = 1'b0;  // [0] block_start

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] crc_out

  word_item_t  word_q[$];
  word_item_t  next_word;
  crc_t        crc_expect_q[$];

  // model state, owned by the input-side predictor
  crc_t        model_crc;
  crc_t        model_seed;

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  bit          steady = 1'b0;

  crc16_parallel_64bit #(.DATA_WIDTH(WORD_W)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Fold one word into the CRC, MSB first, one LFSR shift per bit
  function automatic crc_t fold_crc16(crc_t crc, logic [WORD_W-1:0] word);
    logic fb;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      fb  = crc[CRC_W-1] ^ word[i];
      crc = {crc[CRC_W-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic bit take_idle();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = 64'd1 << $urandom_range(0, WORD_W - 1);
      3: w = ~(64'd1 << $urandom_range(0, WORD_W - 1));
      4: w = {32'd0, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[crc16_parallel_64bit] ERROR");
      $finish;
    end
  end

  // Feed pending words to the input stream, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (word_q.size() != 0 && !take_idle()) begin
        next_word = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_word.data_word;
        s_axis_tuser  <= next_word.block_start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result stream at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_idle();
    end
  end

  // Track seed writes and predict the CRC for each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_crc  = '0;
      model_seed = '0;
    end else begin
      if (cfg_we_i) begin
        model_seed = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          model_crc = model_seed;
        end
        model_crc = fold_crc16(model_crc, s_axis_tdata);
        crc_expect_q.push_back(model_crc);
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (crc_expect_q.size() == 0) begin
        $error("crc_out: no result expected, got %h", m_axis_tdata);
        err_cnt++;
      end else if (crc_expect_q[0] !== m_axis_tdata) begin
        $error("crc_out: expected %h, got %h", crc_expect_q[0], m_axis_tdata);
        err_cnt++;
        void'(crc_expect_q.pop_front());
      end else begin
        void'(crc_expect_q.pop_front());
      end
    end
  end

  task automatic push_word(logic [WORD_W-1:0] w, logic start);
    word_item_t it;
    it.data_word   = w;
    it.block_start = start;
    word_q.push_back(it);
  endtask

  // Hold until every word went out and every result came back
  task automatic drain();
    while (word_q.size() != 0 || s_axis_tvalid || crc_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_seed(logic [15:0] seed);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly plain words, with a block start now and then
  task automatic push_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_word(rand_word(), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    logic [15:0] seeds[4];
    seeds[0] = 16'hFFFF;
    seeds[1] = 16'h0000;
    seeds[2] = 16'(($urandom));
    seeds[3] = CRC_POLY;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Run from the reset CRC with no start, then restart from the reset seed
    push_word(64'h0000_0000_0000_0000, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_word(64'h8000_0000_0000_0000, 1'b0);
    push_word(64'h0000_0000_0000_0001, 1'b0);
    push_word(64'h0000_0000_0000_0000, 1'b1);
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_word(64'h5555_5555_5555_5555, 1'b1);
    drain();

    // Restart blocks from the all-ones seed
    write_seed(16'hFFFF);
    push_word(64'h0000_0000_0000_0000, 1'b1);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    push_word(64'h0123_4567_89AB_CDEF, 1'b0);
    push_word(64'hFEDC_BA98_7654_3210, 1'b1);
    push_word(64'h0000_0001_0000_0000, 1'b0);
    push_word(64'h0000_0000_8000_0000, 1'b0);
    drain();

    // Random phases, one seed each; drain halfway to let the pipe run dry
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      steady = (p == 1);
      push_random(RAND_WORDS / 2);
      drain();
      push_random(RAND_WORDS - RAND_WORDS / 2);
      drain();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk_i);
    if (crc_expect_q.size() != 0) begin
      $error("crc_out: %0d results never arrived", crc_expect_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("[crc16_parallel_64bit] OK");
    end else begin
      $display("[crc16_parallel_64bit] ERROR");
    end
    $finish;
  end

endmodule
